// File: design/float_to_decimal_ascii_assert.svh
// Assertion macros used by the checker file of float_to_decimal_ascii
`ifndef FLOAT_TO_DECIMAL_ASCII_ASSERT_SVH
`define FLOAT_TO_DECIMAL_ASCII_ASSERT_SVH

// concurrent check, switched off while reset is asserted
`define FTA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// concurrent check that also holds across reset
`define FTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/fta_pkg.sv
// Shared types and constants for the float to decimal text converter
package fta_pkg;

    localparam int TEXT_CHARS  = 15;   // text buffer size, one kept for terminator
    localparam int MAX_FRAC    = 7;    // fraction digits at most
    localparam int MAX_RESULTS = 14;   // characters per item at most

    localparam int MANT_BITS = 23;
    localparam int EXP_BIAS  = 127;
    localparam int IP_W      = 31;     // integer part bits (unbiased exponent below 31)
    localparam int FP_W      = 24;     // fraction in units of 2^-24
    localparam int V_W       = MANT_BITS + 1 + IP_W + MANT_BITS - 1;
    localparam int SH_W      = $clog2(IP_W + MANT_BITS);
    localparam int INT_DIGITS = 10;    // decimal digits of a 31-bit value
    localparam int BCD_W     = INT_DIGITS * 4;
    localparam int FD_W      = MAX_FRAC * 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BIG   = 2'd1,
        ST_SMALL = 2'd2
    } t_status;

    typedef struct packed {
        t_status           status;
        logic              sign;
        logic [IP_W-1:0]   ip;
        logic [FP_W-1:0]   fp;
    } t_item;

endpackage

// File: design/fta_front.sv
// Front end: accepts a float pattern, classifies it and splits it into integer/fraction
module fta_front (
    input  logic          i_valid,
    input  logic [31:0]   i_float_bits,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output fta_pkg::t_item o_item
);
    import fta_pkg::*;

    logic [7:0]       w_exp;
    logic [MANT_BITS:0] w_mant;
    logic [SH_W-1:0]  w_sh;
    logic [V_W-1:0]   w_v;
    logic             w_zero;
    logic             w_big;
    logic             w_small;

    assign w_exp   = i_float_bits[30:23];
    assign w_mant  = {1'b1, i_float_bits[MANT_BITS-1:0]};
    assign w_zero  = (i_float_bits[30:0] == 31'd0);
    assign w_big   = (w_exp >= 8'(EXP_BIAS + IP_W));
    assign w_small = (w_exp < 8'(EXP_BIAS - MANT_BITS));
    assign w_sh    = SH_W'(w_exp - 8'(EXP_BIAS - MANT_BITS));
    // value scaled by 2^46: integer part on top, fraction bits just below
    assign w_v     = V_W'(w_mant) << w_sh;

    always_comb begin
        o_item = '0;
        if (w_zero) begin
            o_item.status = ST_OK;
        end else if (w_big) begin
            o_item.status = ST_BIG;
        end else if (w_small) begin
            o_item.status = ST_SMALL;
        end else begin
            o_item.status = ST_OK;
            o_item.sign   = i_float_bits[31];
            o_item.ip     = w_v[MANT_BITS-1+FP_W +: IP_W];
            o_item.fp     = w_v[MANT_BITS-1 +: FP_W];
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// File: design/fta_queue.sv
// Two-entry queue between the front end and the conversion back end
module fta_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fta_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output fta_pkg::t_item o_item
);
    import fta_pkg::*;

    t_item      r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_do_push;
    logic       w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_data[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_data[r_wptr] <= i_item;
        end
    end

endmodule

// File: design/fta_back.sv
// Back end: serial binary to BCD, fraction digit generation and character emit
module fta_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  fta_pkg::t_item i_q_item,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [7:0]     o_text_char,
    output logic           o_last_char,
    output logic [1:0]     o_status
);
    import fta_pkg::*;

    localparam int CNT_W  = $clog2(IP_W);
    localparam int DIG_W  = $clog2(INT_DIGITS);
    localparam int NDIG_W = $clog2(INT_DIGITS + 1);
    localparam int FCNT_W = $clog2(MAX_FRAC + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_SIZE, S_SIGN, S_INT, S_PT, S_FRAC, S_ERR
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sign;
    t_status           r_st;
    logic              r_fz;
    logic [IP_W-1:0]   r_ip;
    logic [FP_W-1:0]   r_fp;
    logic [BCD_W-1:0]  r_bcd;
    logic [FD_W-1:0]   r_fdig;
    logic [DIG_W-1:0]  r_idx;
    logic [FCNT_W-1:0] r_fcnt;
    logic              r_valid;
    logic [7:0]        r_char;
    logic              r_last;
    logic [1:0]        r_ost;

    logic              w_free;
    logic              w_emit;
    logic [BCD_W-1:0]  w_adj;
    logic [FP_W+3:0]   w_fp10;
    logic [NDIG_W-1:0] w_ndig;
    logic [FCNT_W-1:0] w_fcnt;

    assign w_free = !r_valid || !i_stall;
    assign o_pop  = i_q_valid && (r_state == S_IDLE);
    // a character is loaded into the output register this cycle
    assign w_emit = w_free && ((r_state == S_SIGN) || (r_state == S_INT) ||
                               (r_state == S_PT) || (r_state == S_FRAC) ||
                               (r_state == S_ERR));

    // double-dabble correction: digits of 5 or more get 3 added before the shift
    always_comb begin
        for (int i = 0; i < INT_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    assign w_fp10 = ((FP_W+4)'(r_fp) << 3) + ((FP_W+4)'(r_fp) << 1);

    // integer digit count and fraction digit count after trimming trailing zeros
    always_comb begin
        int nb;
        int lim;
        int lastnz;
        int cnt;
        w_ndig = NDIG_W'(1);
        for (int i = 0; i < INT_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                w_ndig = NDIG_W'(i + 1);
            end
        end
        nb  = int'(r_sign) + int'(w_ndig) + 1;
        lim = MAX_RESULTS - nb;
        if (TEXT_CHARS - 1 - nb < lim) begin
            lim = TEXT_CHARS - 1 - nb;
        end
        if (MAX_FRAC < lim) begin
            lim = MAX_FRAC;
        end
        if (lim < 0) begin
            lim = 0;
        end
        lastnz = 0;
        for (int j = 0; j < MAX_FRAC; j++) begin
            if (j < lim && r_fdig[(MAX_FRAC-1-j)*4 +: 4] != 4'd0) begin
                lastnz = j + 1;
            end
        end
        if (r_fz) begin
            cnt = 1;
        end else if (lim == 0) begin
            cnt = 0;
        end else if (lastnz == 0) begin
            cnt = 1;
        end else begin
            cnt = lastnz;
        end
        w_fcnt = FCNT_W'(cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_sign  <= i_q_item.sign;
                        r_st    <= i_q_item.status;
                        r_ip    <= i_q_item.ip;
                        r_fp    <= i_q_item.fp;
                        r_fz    <= (i_q_item.fp == '0);
                        r_bcd   <= '0;
                        r_fdig  <= '0;
                        r_cnt   <= '0;
                        r_state <= (i_q_item.status == ST_OK) ? S_CONV : S_ERR;
                    end
                end
                S_CONV: begin
                    r_bcd <= {w_adj[BCD_W-2:0], r_ip[IP_W-1]};
                    r_ip  <= r_ip << 1;
                    if (r_cnt < CNT_W'(MAX_FRAC)) begin
                        r_fdig <= (r_fdig << 4) | FD_W'(w_fp10[FP_W+3:FP_W]);
                        r_fp   <= w_fp10[FP_W-1:0];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(IP_W - 1)) begin
                        r_state <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    r_idx   <= DIG_W'(w_ndig - 1'b1);
                    r_fcnt  <= w_fcnt;
                    r_state <= r_sign ? S_SIGN : S_INT;
                end
                S_SIGN: begin
                    if (w_free) begin
                        r_char  <= CHAR_MINUS;
                        r_last  <= 1'b0;
                        r_ost   <= ST_OK;
                        r_state <= S_INT;
                    end
                end
                S_INT: begin
                    if (w_free) begin
                        r_char  <= CHAR_ZERO | {4'd0, r_bcd[r_idx*4 +: 4]};
                        r_last  <= 1'b0;
                        r_ost   <= ST_OK;
                        if (r_idx == '0) begin
                            r_state <= S_PT;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                S_PT: begin
                    if (w_free) begin
                        r_char  <= CHAR_POINT;
                        r_last  <= (r_fcnt == '0);
                        r_ost   <= ST_OK;
                        r_state <= (r_fcnt == '0) ? S_IDLE : S_FRAC;
                    end
                end
                S_FRAC: begin
                    if (w_free) begin
                        r_char  <= CHAR_ZERO | {4'd0, r_fdig[FD_W-1 -: 4]};
                        r_last  <= (r_fcnt == FCNT_W'(1));
                        r_ost   <= ST_OK;
                        r_fdig  <= r_fdig << 4;
                        r_fcnt  <= r_fcnt - 1'b1;
                        if (r_fcnt == FCNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (w_free) begin
                        r_char  <= 8'd0;
                        r_last  <= 1'b1;
                        r_ost   <= r_st;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;
    assign o_status    = r_ost;

endmodule

// File: design/float_to_decimal_ascii.sv
// Single-precision float to decimal ASCII text, one character per transaction
//
// Input channel: i_valid/o_stall carry one IEEE 754 single-precision pattern
// (i_float_bits) per transaction. The front end classifies it and splits it
// into integer and fraction parts; a two-entry queue holds up to two items
// ahead of the converter.
// Output channel: o_valid/i_stall carry one character per transaction
// (o_text_char), o_last_char on the final one, o_status 0 for text, 1 for a
// magnitude too large (also inf/NaN) and 2 for too small (also denormals),
// each error being a single transaction with character 0.
// Conversion: a text item passes a binary to BCD shift over the 31 integer
// bits, with the fraction digits formed in the same steps, and a sizing
// state, then goes out as 3 to 14 characters, one per cycle unless stalled.
// An item is taken from the queue only while the converter is idle.
// A stalled output holds its character; the converter waits and the queue
// keeps taking input until it is full. Reset (synchronous, active low)
// empties the queue and drops any item in flight.
module float_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_char,
    output logic        o_last_char,
    output logic [1:0]  o_status
);
    import fta_pkg::*;

    logic  w_full;
    logic  w_push;
    t_item w_front_item;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_q_item;

    fta_front u_front (
        .i_valid      (i_valid),
        .i_float_bits (i_float_bits),
        .i_full       (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    fta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    fta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_pop       (w_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char),
        .o_status    (o_status)
    );

endmodule

// File: design/fta_checker.sv
// Port-level checks for float_to_decimal_ascii and the bind that attaches them
`include "float_to_decimal_ascii_assert.svh"

module fta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_float_bits,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_text_char,
    input logic        o_last_char,
    input logic [1:0]  o_status
);
    import fta_pkg::*;

    `FTA_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid && $stable(i_float_bits), "input transaction changed while stalled")
    `FTA_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_text_char) && $stable(o_last_char) && $stable(o_status), "output transaction changed while stalled")
    `FTA_ASSERT(a_err_form, i_clk, i_rst_n, o_valid && (o_status != ST_OK) |-> o_last_char && (o_text_char == 8'd0) && ((o_status == ST_BIG) || (o_status == ST_SMALL)), "malformed error transaction")
    `FTA_ASSERT(a_text_chars, i_clk, i_rst_n, o_valid && (o_status == ST_OK) |-> ((o_text_char >= CHAR_ZERO) && (o_text_char <= CHAR_NINE)) || (o_text_char == CHAR_MINUS) || (o_text_char == CHAR_POINT), "unexpected text character")
    `FTA_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

bind float_to_decimal_ascii fta_checker u_fta_checker (.*);
